// ===== rtl/dfpa_pkg.sv =====
`timescale 1ns / 1ps
package dfpa_pkg;

    localparam int MAX_SCALE = 9;
    localparam int NUM_CELLS = 64;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_SUB     = 3'd1;
    localparam logic [2:0] CMD_MUL     = 3'd2;
    localparam logic [2:0] CMD_DIV     = 3'd3;
    localparam logic [2:0] CMD_RESCALE = 3'd4;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_SCALE    = 2'd2;
    localparam logic [1:0] ST_DIVZERO  = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        rnd;
        logic        bypass;
        logic [1:0]  st;
        logic [63:0] val;
    } t_ctrl;

    typedef struct packed {
        t_ctrl       ctrl;
        logic [63:0] rem;
        logic [63:0] lq;
        logic [63:0] d;
    } t_cell;

    function automatic logic [63:0] pow10(input logic [3:0] n);
        logic [63:0] p;
        case (n)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            4'd10:   p = 64'd10000000000;
            4'd11:   p = 64'd100000000000;
            4'd12:   p = 64'd1000000000000;
            4'd13:   p = 64'd10000000000000;
            4'd14:   p = 64'd100000000000000;
            default: p = 64'd1000000000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/dfpa_prep.sv =====
`timescale 1ns / 1ps
module dfpa_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [2:0]           i_cmd,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    input  logic [3:0]           i_sc,
    input  logic [3:0]           i_ts,
    output dfpa_pkg::t_cell      o_cell
);
    import dfpa_pkg::*;

    t_ctrl        n0_ctrl, r0_ctrl, r1_ctrl, r2_ctrl;
    logic [63:0]  n0_x, n0_y, n0_d, n0_h;
    logic [63:0]  r0_x, r0_y, r0_d, r0_h;
    logic [63:0]  r1_ll, r1_x1, r1_x2, r1_hh, r1_d, r1_h;
    logic [127:0] n2_p;
    logic [63:0]  r2_hi, r2_lo, r2_d;
    t_cell        n3_cell, r3_cell;
    logic [63:0]  a_mag, b_mag, sum, dif;
    logic         sc_bad, ts_bad;

    always_comb begin
        a_mag  = i_a[63] ? (~i_a + 64'd1) : i_a;
        b_mag  = i_b[63] ? (~i_b + 64'd1) : i_b;
        sum    = i_a + i_b;
        dif    = i_a - i_b;
        sc_bad = i_sc > 4'(MAX_SCALE);
        ts_bad = i_ts > 4'(MAX_SCALE);
        n0_ctrl        = '0;
        n0_ctrl.valid  = i_valid;
        n0_ctrl.bypass = 1'b1;
        n0_ctrl.neg    = i_a[63] ^ i_b[63];
        n0_x = a_mag;
        n0_y = b_mag;
        n0_d = 64'd1;
        n0_h = 64'd0;
        unique case (i_cmd)
            CMD_ADD: begin
                if (!(i_a[63] ^ i_b[63]) && (sum[63] ^ i_a[63])) begin
                    n0_ctrl.st = ST_OVERFLOW;
                end else begin
                    n0_ctrl.val = sum;
                end
            end
            CMD_SUB: begin
                if ((i_a[63] ^ i_b[63]) && (dif[63] ^ i_a[63])) begin
                    n0_ctrl.st = ST_OVERFLOW;
                end else begin
                    n0_ctrl.val = dif;
                end
            end
            CMD_MUL: begin
                if (sc_bad) begin
                    n0_ctrl.st = ST_SCALE;
                end else begin
                    n0_ctrl.bypass = 1'b0;
                    n0_d = pow10(i_sc);
                    n0_h = n0_d >> 1;
                end
            end
            CMD_DIV: begin
                if (sc_bad) begin
                    n0_ctrl.st = ST_SCALE;
                end else if (i_b == 64'd0) begin
                    n0_ctrl.st = ST_DIVZERO;
                end else begin
                    n0_ctrl.bypass = 1'b0;
                    n0_ctrl.rnd    = 1'b1;
                    n0_y = pow10(i_sc);
                    n0_d = b_mag;
                end
            end
            CMD_RESCALE: begin
                n0_ctrl.neg = i_a[63];
                if (sc_bad || ts_bad) begin
                    n0_ctrl.st = ST_SCALE;
                end else if (i_sc == i_ts) begin
                    n0_ctrl.val = i_a;
                end else if (i_ts > i_sc) begin
                    n0_ctrl.bypass = 1'b0;
                    n0_y = pow10(i_ts - i_sc);
                end else begin
                    n0_ctrl.bypass = 1'b0;
                    n0_ctrl.rnd    = 1'b1;
                    n0_y = 64'd1;
                    n0_d = pow10(i_sc - i_ts);
                end
            end
            default: begin
                n0_ctrl.val = 64'd0;
            end
        endcase
    end

    always_comb begin
        n2_p = {64'd0, r1_ll} + {32'd0, r1_x1, 32'd0} + {32'd0, r1_x2, 32'd0}
             + {r1_hh, 64'd0} + {64'd0, r1_h};
    end

    always_comb begin
        n3_cell.ctrl = r2_ctrl;
        n3_cell.rem  = r2_hi;
        n3_cell.lq   = r2_lo;
        n3_cell.d    = r2_d;
        if (!r2_ctrl.bypass && (r2_hi >= r2_d)) begin
            n3_cell.ctrl.bypass = 1'b1;
            n3_cell.ctrl.st     = ST_OVERFLOW;
            n3_cell.ctrl.val    = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctrl.valid <= 1'b0;
            r1_ctrl.valid <= 1'b0;
            r2_ctrl.valid <= 1'b0;
            r3_cell.ctrl.valid <= 1'b0;
        end else if (i_adv) begin
            r0_ctrl <= n0_ctrl;
            r0_x    <= n0_x;
            r0_y    <= n0_y;
            r0_d    <= n0_d;
            r0_h    <= n0_h;
            r1_ctrl <= r0_ctrl;
            r1_ll   <= {32'd0, r0_x[31:0]} * {32'd0, r0_y[31:0]};
            r1_x1   <= {32'd0, r0_x[63:32]} * {32'd0, r0_y[31:0]};
            r1_x2   <= {32'd0, r0_x[31:0]} * {32'd0, r0_y[63:32]};
            r1_hh   <= {32'd0, r0_x[63:32]} * {32'd0, r0_y[63:32]};
            r1_d    <= r0_d;
            r1_h    <= r0_h;
            r2_ctrl <= r1_ctrl;
            r2_hi   <= n2_p[127:64];
            r2_lo   <= n2_p[63:0];
            r2_d    <= r1_d;
            r3_cell <= n3_cell;
        end
    end

    assign o_cell = r3_cell;

endmodule

// ===== rtl/dfpa_cell.sv =====
`timescale 1ns / 1ps
module dfpa_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  dfpa_pkg::t_cell i_cell,
    output dfpa_pkg::t_cell o_cell
);
    import dfpa_pkg::*;

    t_cell       n_cell, r_cell;
    logic [63:0] sh;
    logic        take;

    always_comb begin
        sh     = {i_cell.rem[62:0], i_cell.lq[63]};
        take   = i_cell.rem[63] || (sh >= i_cell.d);
        n_cell = i_cell;
        n_cell.rem = take ? (sh - i_cell.d) : sh;
        n_cell.lq  = {i_cell.lq[62:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.ctrl.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/dfpa_finish.sv =====
`timescale 1ns / 1ps
module dfpa_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  dfpa_pkg::t_cell i_cell,
    output logic            o_valid,
    output logic [63:0]     o_value,
    output logic [1:0]      o_status
);
    import dfpa_pkg::*;

    t_ctrl       n1_ctrl, r1_ctrl;
    logic [63:0] n1_mag, r1_mag;
    logic [63:0] n_value, r_value;
    logic [1:0]  n_status, r_status;
    logic        r_valid;

    always_comb begin
        n1_ctrl = i_cell.ctrl;
        n1_mag  = i_cell.lq;
        if (!i_cell.ctrl.bypass && i_cell.ctrl.rnd
            && (i_cell.rem >= (i_cell.d - i_cell.rem))) begin
            if (&i_cell.lq) begin
                n1_ctrl.bypass = 1'b1;
                n1_ctrl.st     = ST_OVERFLOW;
                n1_ctrl.val    = 64'd0;
            end else begin
                n1_mag = i_cell.lq + 64'd1;
            end
        end
    end

    always_comb begin
        n_value  = 64'd0;
        n_status = ST_NONE;
        if (r1_ctrl.bypass) begin
            n_status = r1_ctrl.st;
            n_value  = (r1_ctrl.st == ST_NONE) ? r1_ctrl.val : 64'd0;
        end else if (r1_ctrl.neg) begin
            if (r1_mag > 64'h8000_0000_0000_0000) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_value = ~r1_mag + 64'd1;
            end
        end else begin
            if (r1_mag[63]) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_value = r1_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else if (i_adv) begin
            r1_ctrl  <= n1_ctrl;
            r1_mag   <= n1_mag;
            r_valid  <= r1_ctrl.valid;
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ===== rtl/decimal_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// Signed 64-bit decimal fixed-point ALU: add, subtract, multiply, divide, rescale.
// Operations arrive on the slave stream (i_s_tvalid, o_s_tready, i_s_tdata) and
// results leave on the master stream (o_m_tvalid, i_m_tready, o_m_tdata).
// Every transaction carries one operation and produces exactly one result.
// The datapath is a fixed pipeline: four stages of decode, partial products,
// summation and a quotient range check, a chain of 64 division cells retiring one
// quotient bit each, and two stages for rounding, sign and range checks.
// Throughput is one transaction per cycle while the receiver does not stall; the
// chain of division cells sets the latency, and each cell holds a different
// operation at the same time.
// When the receiver stalls, the whole pipeline holds and o_s_tready drops until
// the output register is taken. A synchronous active-low reset clears every
// valid flag, so the pipeline comes out of reset empty and ready.
// Errors (overflow, unsupported scale, divide by zero) return a zero value.
module decimal_fixed_point_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // command[2:0], left_operand[66:3], right_operand[130:67],
    // scale[134:131], target_scale[138:135], zero fill above.
    input  logic [143:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // result_value[63:0], status[65:64], zero fill above.
    output logic [71:0]   o_m_tdata
);
    import dfpa_pkg::*;

    logic        adv;
    t_cell       chain [NUM_CELLS+1];
    logic [63:0] value;
    logic [1:0]  status;

    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    dfpa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tdata[2:0]),
        .i_a     (i_s_tdata[66:3]),
        .i_b     (i_s_tdata[130:67]),
        .i_sc    (i_s_tdata[134:131]),
        .i_ts    (i_s_tdata[138:135]),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        dfpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    dfpa_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cell   (chain[NUM_CELLS]),
        .o_valid  (o_m_tvalid),
        .o_value  (value),
        .o_status (status)
    );

    assign o_m_tdata = {6'd0, status, value};

endmodule
